[rtl/lom_pkg.sv]
// Package for the limit order matcher: side codes, field widths and the
// sequencer state type. No dependencies.
package lom_pkg;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam int PRICE_W = 20;
  localparam int VOL_W   = 16;
  localparam int TAG_W   = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TRADE,
    ST_REP_IN,
    ST_REP_REST,
    ST_SHIFT,
    ST_REST,
    ST_REJECT
  } state_t;

  // Control from the sequencer into the book datapath.
  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic rest_write;
    logic apply_trade;
    logic shift_step;
    logic shift_done;
  } book_ctl_t;

endpackage

[rtl/lom_book.sv]
// One side of the order book: price, volume and tag memories plus count.
// Depends on lom_pkg.
module lom_book #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sel,
  input  lom_pkg::book_ctl_t           ctl,
  input  logic [$clog2(BOOK_DEPTH)-1:0] rd_idx,
  input  logic [$clog2(BOOK_DEPTH)-1:0] wr_idx,
  input  logic [lom_pkg::VOL_W-1:0]    wr_vol,
  input  logic [lom_pkg::PRICE_W-1:0]  rest_price,
  input  logic [lom_pkg::VOL_W-1:0]    rest_vol,
  input  logic [lom_pkg::TAG_W-1:0]    rest_tag,
  output logic [$clog2(BOOK_DEPTH+1)-1:0] count,
  output logic [lom_pkg::PRICE_W-1:0]  rd_price,
  output logic [lom_pkg::VOL_W-1:0]    rd_vol,
  output logic [lom_pkg::TAG_W-1:0]    rd_tag
);
  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH+1);

  logic [lom_pkg::PRICE_W-1:0] price_mem [BOOK_DEPTH];
  logic [lom_pkg::VOL_W-1:0]   vol_mem   [BOOK_DEPTH];
  logic [lom_pkg::TAG_W-1:0]   tag_mem   [BOOK_DEPTH];

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_price <= price_mem[rd_idx];
    rd_vol   <= vol_mem[rd_idx];
    rd_tag   <= tag_mem[rd_idx];
  end

  // Single write port: rest append, trade volume update, or shift down one entry.
  always_ff @(posedge clk) begin
    if (sel && ctl.rest_write) begin
      price_mem[count[IW-1:0]] <= rest_price;
      vol_mem[count[IW-1:0]]   <= rest_vol;
      tag_mem[count[IW-1:0]]   <= rest_tag;
    end else if (sel && ctl.apply_trade) begin
      vol_mem[wr_idx] <= wr_vol;
    end else if (sel && ctl.shift_step) begin
      price_mem[wr_idx] <= rd_price;
      vol_mem[wr_idx]   <= rd_vol;
      tag_mem[wr_idx]   <= rd_tag;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (sel && ctl.rest_write) begin
      count <= count + CW'(1);
    end else if (sel && ctl.shift_done) begin
      count <= count - CW'(1);
    end
  end
endmodule

[rtl/lom_ctrl.sv]
// Matching sequencer: best-price scan, trade, reports, removal, resting.
// Depends on lom_pkg.
module lom_ctrl #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [lom_pkg::PRICE_W-1:0]   price,
  input  logic [lom_pkg::VOL_W-1:0]     volume,
  input  logic [lom_pkg::TAG_W-1:0]     order_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lom_pkg::TAG_W-1:0]     report_tag,
  output logic [lom_pkg::VOL_W-1:0]     traded_volume,
  output logic                          fully_filled,
  output logic                          rejected,
  output logic                          last,
  output lom_pkg::book_ctl_t            ctl,
  output logic                          side,
  output logic [$clog2(BOOK_DEPTH)-1:0] rd_idx,
  output logic [$clog2(BOOK_DEPTH)-1:0] wr_idx,
  output logic [lom_pkg::VOL_W-1:0]     wr_vol,
  output logic [lom_pkg::PRICE_W-1:0]   cur_price,
  output logic [lom_pkg::VOL_W-1:0]     cur_vol,
  output logic [lom_pkg::TAG_W-1:0]     cur_tag,
  input  logic [$clog2(BOOK_DEPTH+1)-1:0] opp_count,
  input  logic [$clog2(BOOK_DEPTH+1)-1:0] own_count,
  input  logic [lom_pkg::PRICE_W-1:0]   rd_price,
  input  logic [lom_pkg::VOL_W-1:0]     rd_vol,
  input  logic [lom_pkg::TAG_W-1:0]     rd_tag
);
  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH+1);

  lom_pkg::state_t state, state_next;

  logic [CW-1:0]               scan_ptr;
  logic                        cmp_valid;
  logic [IW-1:0]               cmp_idx;
  logic [IW-1:0]               best_idx;
  logic [lom_pkg::PRICE_W-1:0] best_price;
  logic [lom_pkg::VOL_W-1:0]   best_vol;
  logic [lom_pkg::TAG_W-1:0]   best_tag;
  logic [lom_pkg::VOL_W-1:0]   qty;
  logic [lom_pkg::VOL_W-1:0]   rest_left;
  logic                        out_busy;
  logic                        better;
  logic                        crosses;
  logic                        shift_end;
  logic [CW-1:0]               shift_ptr;
  logic                        pend_valid;
  logic [lom_pkg::TAG_W-1:0]   pend_tag;
  logic [lom_pkg::VOL_W-1:0]   pend_qty;
  logic                        pend_full;
  logic                        more_trade;
  logic                        rest_last;

  // Shared compare unit: candidate beats current best, or current best crosses.
  always_comb begin
    if (side == lom_pkg::SIDE_BUY) begin
      better  = rd_price < best_price;
      crosses = best_price <= cur_price;
    end else begin
      better  = rd_price > best_price;
      crosses = best_price >= cur_price;
    end
  end

  assign out_busy  = out_valid && !out_ready;
  assign shift_end = (shift_ptr + CW'(1)) >= opp_count;

  // The resting side's report waits until the next decision is known, so
  // that it can tell whether it closes the order.
  assign more_trade = (cur_vol != '0) && (opp_count != '0) && crosses;
  assign rest_last  = (cur_vol == '0) ||
                      (!more_trade && own_count < CW'(BOOK_DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lom_pkg::ST_IDLE: begin
        if (in_valid && in_ready && volume != '0) state_next = lom_pkg::ST_SCAN;
      end
      lom_pkg::ST_SCAN: begin
        if (opp_count == '0)
          state_next = pend_valid ? lom_pkg::ST_REP_REST : lom_pkg::ST_REST;
        else if (cmp_valid && {1'b0, cmp_idx} == opp_count - CW'(1))
          state_next = lom_pkg::ST_DECIDE;
      end
      lom_pkg::ST_DECIDE: begin
        if (pend_valid) state_next = lom_pkg::ST_REP_REST;
        else state_next = crosses ? lom_pkg::ST_TRADE : lom_pkg::ST_REST;
      end
      lom_pkg::ST_TRADE:   state_next = lom_pkg::ST_REP_IN;
      lom_pkg::ST_REP_IN: begin
        if (!out_busy) begin
          if (rest_left == '0) state_next = lom_pkg::ST_SHIFT;
          else state_next = lom_pkg::ST_REP_REST;
        end
      end
      lom_pkg::ST_REP_REST: begin
        if (!out_busy) begin
          if (cur_vol == '0) state_next = lom_pkg::ST_IDLE;
          else if (more_trade) state_next = lom_pkg::ST_TRADE;
          else state_next = lom_pkg::ST_REST;
        end
      end
      lom_pkg::ST_SHIFT: begin
        if (shift_end)
          state_next = (cur_vol == '0) ? lom_pkg::ST_REP_REST : lom_pkg::ST_SCAN;
      end
      lom_pkg::ST_REST: begin
        if (own_count < CW'(BOOK_DEPTH)) state_next = lom_pkg::ST_IDLE;
        else state_next = lom_pkg::ST_REJECT;
      end
      lom_pkg::ST_REJECT: begin
        if (!out_busy) state_next = lom_pkg::ST_IDLE;
      end
      default: state_next = lom_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the books.
  always_comb begin
    ctl      = '0;
    rd_idx   = scan_ptr[IW-1:0];
    wr_idx   = best_idx;
    wr_vol   = best_vol - qty;
    in_ready = (state == lom_pkg::ST_IDLE) && !out_busy;
    unique case (state)
      lom_pkg::ST_SCAN:     ctl.scan_step = 1'b1;
      lom_pkg::ST_TRADE:    ctl.apply_trade = 1'b1;
      lom_pkg::ST_SHIFT: begin
        rd_idx          = IW'(shift_ptr + CW'(1));
        wr_idx          = shift_ptr[IW-1:0];
        ctl.shift_step  = cmp_valid;
        ctl.shift_done  = shift_end;
      end
      lom_pkg::ST_REST:     ctl.rest_write = own_count < CW'(BOOK_DEPTH);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lom_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Read-data valid flag for the scan and the shift.
  always_ff @(posedge clk) begin
    if (state == lom_pkg::ST_SCAN) cmp_valid <= scan_ptr < opp_count;
    else if (state == lom_pkg::ST_SHIFT) cmp_valid <= !cmp_valid && !shift_end;
    else cmp_valid <= 1'b0;
  end

  // A resting side report is owed from each trade until it is sent.
  always_ff @(posedge clk) begin
    if (rst) pend_valid <= 1'b0;
    else if (state == lom_pkg::ST_TRADE) pend_valid <= 1'b1;
    else if (state == lom_pkg::ST_REP_REST && !out_busy) pend_valid <= 1'b0;
  end

  // Order registers, scan pointer, best-so-far tracking, trade quantity and shift pointer.
  always_ff @(posedge clk) begin
    unique case (state)
      lom_pkg::ST_IDLE: begin
        side      <= mode;
        cur_price <= price;
        cur_vol   <= volume;
        cur_tag   <= order_tag;
        scan_ptr  <= '0;
      end
      lom_pkg::ST_SCAN: begin
        if (scan_ptr < opp_count) begin
          scan_ptr  <= scan_ptr + CW'(1);
          cmp_idx   <= scan_ptr[IW-1:0];
        end
        if (cmp_valid && (cmp_idx == '0 || better)) begin
          best_idx   <= cmp_idx;
          best_price <= rd_price;
          best_vol   <= rd_vol;
          best_tag   <= rd_tag;
        end
      end
      lom_pkg::ST_DECIDE: begin
        qty <= (cur_vol < best_vol) ? cur_vol : best_vol;
      end
      lom_pkg::ST_TRADE: begin
        cur_vol   <= cur_vol - qty;
        rest_left <= best_vol - qty;
        scan_ptr  <= '0;
        pend_tag  <= best_tag;
        pend_qty  <= qty;
        pend_full <= best_vol == qty;
      end
      lom_pkg::ST_REP_IN: begin
        shift_ptr <= {1'b0, best_idx};
      end
      lom_pkg::ST_SHIFT: begin
        // Read of entry i+1 is registered and lands in the next cycle; write it into i then advance.
        if (cmp_valid) shift_ptr <= shift_ptr + CW'(1);
      end
      default: ;
    endcase
  end

  // Output register holding one report beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_busy) begin
      if (state == lom_pkg::ST_REP_IN) begin
        out_valid     <= 1'b1;
        report_tag    <= cur_tag;
        traded_volume <= qty;
        fully_filled  <= cur_vol == '0;
        rejected      <= 1'b0;
        last          <= 1'b0;
      end else if (state == lom_pkg::ST_REP_REST) begin
        out_valid     <= 1'b1;
        report_tag    <= pend_tag;
        traded_volume <= pend_qty;
        fully_filled  <= pend_full;
        rejected      <= 1'b0;
        last          <= rest_last;
      end else if (state == lom_pkg::ST_REJECT) begin
        out_valid     <= 1'b1;
        report_tag    <= cur_tag;
        traded_volume <= '0;
        fully_filled  <= 1'b0;
        rejected      <= 1'b1;
        last          <= 1'b1;
      end else begin
        out_valid     <= 1'b0;
      end
    end
  end
endmodule

[rtl/limit_order_matcher.sv]
// Top level of the limit order matcher: sequencer plus buy and sell books.
// Depends on lom_pkg, lom_ctrl and lom_book.
//
// Usage: one order beat enters on in_valid/in_ready (mode, price, volume,
// order_tag). Report beats leave on out_valid/out_ready, two per fill
// (incoming order, then resting order) or one per reject, with last on the
// final report of the order. A zero-volume order gives no beat; an order
// that neither trades nor is rejected gives none. Each trade costs a
// best-price scan of the opposite book (through the registered read port
// and one shared comparator), a trade and report step, and for a removed
// order a shift down of every entry behind it. The resting side's report
// goes out after the next scan when the incoming order has volume left,
// else directly, once it is known whether it is the last.
// in_ready is high only while the sequencer is idle and no report waits.
// When the receiver stalls, the sequencer holds at the report step.
// Reset (synchronous, rst high) empties both books at once by clearing
// their counts; no clearing pass runs.
module limit_order_matcher #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [lom_pkg::PRICE_W-1:0] price,
  input  logic [lom_pkg::VOL_W-1:0]   volume,
  input  logic [lom_pkg::TAG_W-1:0]   order_tag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lom_pkg::TAG_W-1:0]   report_tag,
  output logic [lom_pkg::VOL_W-1:0]   traded_volume,
  output logic                        fully_filled,
  output logic                        rejected,
  output logic                        last
);
  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH+1);

  lom_pkg::book_ctl_t          ctl;
  logic                        side;
  logic [IW-1:0]               rd_idx, wr_idx;
  logic [lom_pkg::VOL_W-1:0]   wr_vol, cur_vol;
  logic [lom_pkg::PRICE_W-1:0] cur_price;
  logic [lom_pkg::TAG_W-1:0]   cur_tag;
  logic [CW-1:0]               buy_count, sell_count, opp_count, own_count;
  logic [lom_pkg::PRICE_W-1:0] buy_price, sell_price, rd_price;
  logic [lom_pkg::VOL_W-1:0]   buy_vol, sell_vol, rd_vol;
  logic [lom_pkg::TAG_W-1:0]   buy_tag, sell_tag, rd_tag;
  logic                        buy_opp, sell_opp;
  lom_pkg::book_ctl_t          buy_ctl, sell_ctl;

  // A buy order matches against sells and rests in buys.
  assign sell_opp  = side == lom_pkg::SIDE_BUY;
  assign buy_opp   = !sell_opp;
  assign opp_count = sell_opp ? sell_count : buy_count;
  assign own_count = sell_opp ? buy_count : sell_count;
  assign rd_price  = sell_opp ? sell_price : buy_price;
  assign rd_vol    = sell_opp ? sell_vol : buy_vol;
  assign rd_tag    = sell_opp ? sell_tag : buy_tag;

  // Scan, trade and shift go to the opposite book; resting to the own book.
  always_comb begin
    buy_ctl  = ctl;
    sell_ctl = ctl;
    buy_ctl.rest_write  = ctl.rest_write && sell_opp;
    sell_ctl.rest_write = ctl.rest_write && buy_opp;
    buy_ctl.apply_trade = ctl.apply_trade && buy_opp;
    sell_ctl.apply_trade = ctl.apply_trade && sell_opp;
    buy_ctl.shift_step  = ctl.shift_step && buy_opp;
    sell_ctl.shift_step = ctl.shift_step && sell_opp;
    buy_ctl.shift_done  = ctl.shift_done && buy_opp;
    sell_ctl.shift_done = ctl.shift_done && sell_opp;
  end

  lom_ctrl #(.BOOK_DEPTH(BOOK_DEPTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .mode, .price, .volume, .order_tag,
    .out_valid, .out_ready, .report_tag, .traded_volume, .fully_filled,
    .rejected, .last, .ctl, .side, .rd_idx, .wr_idx, .wr_vol, .cur_price,
    .cur_vol, .cur_tag, .opp_count, .own_count, .rd_price, .rd_vol, .rd_tag
  );

  lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_buy (
    .clk, .rst, .sel(1'b1), .ctl(buy_ctl), .rd_idx, .wr_idx, .wr_vol,
    .rest_price(cur_price), .rest_vol(cur_vol), .rest_tag(cur_tag),
    .count(buy_count), .rd_price(buy_price), .rd_vol(buy_vol), .rd_tag(buy_tag)
  );

  lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_sell (
    .clk, .rst, .sel(1'b1), .ctl(sell_ctl), .rd_idx, .wr_idx, .wr_vol,
    .rest_price(cur_price), .rest_vol(cur_vol), .rest_tag(cur_tag),
    .count(sell_count), .rd_price(sell_price), .rd_vol(sell_vol),
    .rd_tag(sell_tag)
  );
endmodule

[rtl/lom_checker.sv]
// Port-level checks for the limit order matcher, bound to the top level.
// Depends on lom_pkg.
module lom_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lom_pkg::VOL_W-1:0] traded_volume,
  input logic                      fully_filled,
  input logic                      rejected,
  input logic                      last
);
  // A reject beat always closes the order and carries no volume.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> last && traded_volume == '0 && !fully_filled)
    else $error("reject beat malformed");

  // A fill beat always moves volume.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rejected |-> traded_volume != '0)
    else $error("fill beat with zero volume");

  // No new order is taken while a report is pending.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready during stalled report");

  // A stalled report beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(traded_volume))
    else $error("report beat changed while stalled");
endmodule

bind limit_order_matcher lom_checker u_lom_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready,
  .traded_volume, .fully_filled, .rejected, .last
);

[dv/tb_limit_order_matcher.sv]
// Testbench for limit_order_matcher: drives orders, predicts fill and reject
// reports with a price-time matching model of both books. Depends on lom_pkg.
`timescale 1ns / 1ps

module tb_limit_order_matcher;

  localparam int DEPTH    = 16;
  localparam int WDOG_MAX = 40000;

  typedef struct packed {
    logic [lom_pkg::TAG_W-1:0] tag;
    logic [lom_pkg::VOL_W-1:0] qty;
    logic                      full;
    logic                      rej;
    logic                      last;
  } report_t;

  typedef struct {
    logic [lom_pkg::PRICE_W-1:0] price;
    logic [lom_pkg::VOL_W-1:0]   vol;
    logic [lom_pkg::TAG_W-1:0]   tag;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = lom_pkg::SIDE_BUY;
  logic [lom_pkg::PRICE_W-1:0] price = '0;
  logic [lom_pkg::VOL_W-1:0] volume = '0;
  logic [lom_pkg::TAG_W-1:0] order_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lom_pkg::TAG_W-1:0] report_tag;
  logic [lom_pkg::VOL_W-1:0] traded_volume;
  logic fully_filled, rejected, last;

  // Model books, oldest order at index 0.
  entry_t buy_book[$];
  entry_t sell_book[$];
  report_t pending_reports[$];
  int errors = 0;
  int idle_cycles = 0;
  logic rx_stall_on = 1'b1;

  limit_order_matcher #(.BOOK_DEPTH(DEPTH)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Skewed gap length: mostly short, sometimes long.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic void push_report(logic [lom_pkg::TAG_W-1:0] t,
                                      logic [lom_pkg::VOL_W-1:0] q,
                                      logic f, logic r);
    report_t rep;
    rep = '{tag: t, qty: q, full: f, rej: r, last: 1'b0};
    pending_reports.push_back(rep);
  endfunction

  // Match one order against the opposite book, then rest or reject.
  function automatic void match_order(logic side, logic [lom_pkg::PRICE_W-1:0] px,
                                      logic [lom_pkg::VOL_W-1:0] v,
                                      logic [lom_pkg::TAG_W-1:0] t);
    int first_new;
    int best;
    logic crosses;
    logic [lom_pkg::VOL_W-1:0] q;
    entry_t e;
    first_new = pending_reports.size();
    if (v == 0) return;
    forever begin
      if (v == 0) break;
      if (side == lom_pkg::SIDE_BUY ? sell_book.size() == 0 : buy_book.size() == 0)
        break;
      best = 0;
      if (side == lom_pkg::SIDE_BUY) begin
        for (int i = 1; i < sell_book.size(); i++)
          if (sell_book[i].price < sell_book[best].price) best = i;
        e = sell_book[best];
        crosses = e.price <= px;
      end else begin
        for (int i = 1; i < buy_book.size(); i++)
          if (buy_book[i].price > buy_book[best].price) best = i;
        e = buy_book[best];
        crosses = e.price >= px;
      end
      if (!crosses) break;
      q = (v < e.vol) ? v : e.vol;
      v -= q;
      e.vol -= q;
      push_report(t, q, v == 0, 1'b0);
      push_report(e.tag, q, e.vol == 0, 1'b0);
      if (side == lom_pkg::SIDE_BUY) begin
        if (e.vol == 0) sell_book.delete(best);
        else sell_book[best] = e;
      end else begin
        if (e.vol == 0) buy_book.delete(best);
        else buy_book[best] = e;
      end
    end
    if (v != 0) begin
      e = '{price: px, vol: v, tag: t};
      if (side == lom_pkg::SIDE_BUY && buy_book.size() < DEPTH)
        buy_book.push_back(e);
      else if (side == lom_pkg::SIDE_SELL && sell_book.size() < DEPTH)
        sell_book.push_back(e);
      else push_report(t, '0, 1'b0, 1'b1);
    end
    if (pending_reports.size() > first_new)
      pending_reports[pending_reports.size() - 1].last = 1'b1;
  endfunction

  // Send one order beat; the prediction is made at acceptance. Called and
  // returns at a falling edge; valid drops only when a gap follows.
  task automatic send_order(logic side, logic [lom_pkg::PRICE_W-1:0] px,
                            logic [lom_pkg::VOL_W-1:0] v,
                            logic [lom_pkg::TAG_W-1:0] t, logic gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    mode <= side;
    price <= px;
    volume <= v;
    order_tag <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    match_order(side, px, v, t);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stalls at random, changed at the falling edge.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (!rx_stall_on) begin
        out_ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Report checker.
  always @(posedge clk) begin
    report_t got, exp_rep;
    if (!rst && out_valid && out_ready) begin
      got = '{tag: report_tag, qty: traded_volume, full: fully_filled,
              rej: rejected, last: last};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report tag=%0d qty=%0d", $time, report_tag,
                 traded_volume);
        errors++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (got !== exp_rep) begin
          $display("%0t: report mismatch expected tag=%0d qty=%0d full=%0b rej=%0b last=%0b",
                   $time, exp_rep.tag, exp_rep.qty, exp_rep.full, exp_rep.rej,
                   exp_rep.last);
          $display("%0t:                   actual tag=%0d qty=%0d full=%0b rej=%0b last=%0b",
                   $time, got.tag, got.qty, got.full, got.rej, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb_limit_order_matcher NOT OK");
      $finish;
    end
  end

  // Extremes of every field, zero volume, no cross, exact and partial fills.
  task automatic test_directed();
    send_order(lom_pkg::SIDE_BUY, 20'd100, 16'd0, 8'h00, 1'b0);
    send_order(lom_pkg::SIDE_SELL, 20'hFFFFF, 16'd10, 8'hFF, 1'b0);
    send_order(lom_pkg::SIDE_BUY, 20'd0, 16'd5, 8'h01, 1'b1);
    send_order(lom_pkg::SIDE_BUY, 20'hFFFFF, 16'd4, 8'h02, 1'b0);
    send_order(lom_pkg::SIDE_BUY, 20'hFFFFF, 16'd6, 8'h03, 1'b1);
    send_order(lom_pkg::SIDE_SELL, 20'd0, 16'hFFFF, 8'hAA, 1'b0);
    send_order(lom_pkg::SIDE_BUY, 20'hFFFFF, 16'hFFFF, 8'h55, 1'b0);
    send_order(lom_pkg::SIDE_SELL, 20'd50, 16'd3, 8'h10, 1'b1);
    send_order(lom_pkg::SIDE_SELL, 20'd50, 16'd3, 8'h11, 1'b0);
    send_order(lom_pkg::SIDE_SELL, 20'd40, 16'd2, 8'h12, 1'b0);
    send_order(lom_pkg::SIDE_BUY, 20'd50, 16'd7, 8'h13, 1'b1);
    send_order(lom_pkg::SIDE_BUY, 20'd49, 16'd1, 8'h14, 1'b0);
    wait_drained();
  endtask

  // Fill the sell book, then reject, then sweep it with one order; the same for the buy book.
  task automatic test_book_full();
    for (int i = 0; i < DEPTH + 2; i++)
      send_order(lom_pkg::SIDE_SELL, 20'd1000 + 20'($urandom_range(0, 20)), 16'd2,
                 8'(i), 1'b1);
    send_order(lom_pkg::SIDE_BUY, 20'hFFFFF, 16'hFFFF, 8'hEE, 1'b0);
    for (int i = 0; i < DEPTH + 1; i++)
      send_order(lom_pkg::SIDE_BUY, 20'd10, 16'd1, 8'(i), 1'b0);
    send_order(lom_pkg::SIDE_SELL, 20'd0, 16'hFFFF, 8'hDD, 1'b1);
    wait_drained();
  endtask

  // Random orders around a fixed mid price; a few with full-range fields.
  task automatic test_random(int count);
    logic [lom_pkg::PRICE_W-1:0] px;
    logic [lom_pkg::VOL_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      rx_stall_on = (i / 100) % 3 != 2;
      if ($urandom_range(0, 15) == 0) px = 20'($urandom());
      else px = 20'd500000 + 20'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
        0: v = 16'($urandom());
        1: v = 16'd0;
        default: v = 16'($urandom_range(1, 30));
      endcase
      send_order(1'($urandom()), px, v, 8'($urandom()), (i / 50) % 4 != 3);
    end
    rx_stall_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_book_full();
    test_random(400);
    if (errors == 0) $display("tb_limit_order_matcher OK");
    else $display("tb_limit_order_matcher NOT OK");
    $finish;
  end

endmodule
